>>> hdl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and constants for the free range allocator.
// ----------------------------------------------------------------------------
package fra_pkg;

   localparam int MAX_RANGES_DEFAULT = 64;
   localparam int ADDR_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH        = 32;

   // request kinds
   typedef enum logic [1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_MARK  = 2'd2
   } func_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NO_FIT = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_DONE
   } state_type;

   // what the engine decided for the entry at the head of the chain
   typedef struct packed {
      logic [1:0] n_out;   // entries written back: 0, 1 or 2
      logic       absorb;  // entry merged into the pending free range
      logic       place;   // pending free range placed (or dropped) here
      logic       hit;     // alloc found its entry
      logic       drop;    // table full, a range was lost
   } act_type;

endpackage

>>> hdl/free_range_allocator_unit.sv
// ----------------------------------------------------------------------------
// free_range_allocator_unit
// First-fit allocator over a base-sorted table of free ranges with merging.
// ----------------------------------------------------------------------------
// An accepted request runs over all count table entries in turn, where
// count is the number of table entries at that time (at most MAX_RANGES):
// the table lives in a chain of cells that shifts one entry per cycle past a
// single decision step at the head, and rewritten entries drop back into the
// chain behind the ones still waiting. A closing cycle places a freed range
// that lies above every entry, the result is posted after it, and the next
// request is taken in the cycle after the post. Requests are taken one at a
// time; a posted result may wait on rsp_stall while the next request runs.
// ----------------------------------------------------------------------------
module free_range_allocator_unit #(
   parameter int MAX_RANGES = fra_pkg::MAX_RANGES_DEFAULT,
   parameter int ADDR_WIDTH = fra_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_base,
   input  logic [31:0] req_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_res_base,
   output logic [31:0] rsp_res_size,
   output logic [1:0]  rsp_status
);

   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int FW = fra_pkg::FIELD_WIDTH;

   fra_pkg::state_type state_ff, state_in;

   // request registers
   fra_pkg::func_type     func_ff, func_in;
   logic [ADDR_WIDTH-1:0] op_base_ff, op_base_in;
   logic [ADDR_WIDTH-1:0] op_size_ff, op_size_in;
   logic [ADDR_WIDTH:0]   op_end_ff, op_end_in;
   logic [ADDR_WIDTH:0]   pend_base_ff, pend_base_in;
   logic [ADDR_WIDTH:0]   pend_end_ff, pend_end_in;
   logic                  pend_ff, pend_in;
   logic                  found_ff, found_in;
   logic                  full_ff, full_in;
   logic [ADDR_WIDTH-1:0] alloc_base_ff, alloc_base_in;

   // table bookkeeping
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] live_ff, live_in;
   logic [CW-1:0] rem_ff, rem_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]          rsp_base_ff, rsp_base_in;
   logic [FW-1:0]          rsp_size_ff, rsp_size_in;
   fra_pkg::status_type    rsp_status_ff, rsp_status_in;

   // sequencer outputs
   logic accept;
   logic do_scan;
   logic do_flush;
   logic do_post;

   // request decode
   logic [ADDR_WIDTH-1:0] in_base;
   logic [ADDR_WIDTH-1:0] in_size;
   logic [ADDR_WIDTH-1:0] clip_size;
   logic                  active;
   logic                  room;
   logic                  flush_place;
   logic [ADDR_WIDTH:0]   pend_len;

   // chain wiring
   logic [ADDR_WIDTH-1:0] cell_base [MAX_RANGES];
   logic [ADDR_WIDTH-1:0] cell_size [MAX_RANGES];
   logic [CW-1:0]         live_dec;
   logic [IW-1:0]         wr_addr0;
   logic [IW-1:0]         wr_addr1;
   logic                  we0;
   logic                  we1;
   logic [ADDR_WIDTH-1:0] wr_base0;
   logic [ADDR_WIDTH-1:0] wr_size0;
   logic [ADDR_WIDTH-1:0] eng_base0;
   logic [ADDR_WIDTH-1:0] eng_size0;
   logic [ADDR_WIDTH-1:0] eng_base1;
   logic [ADDR_WIDTH-1:0] eng_size1;
   logic [ADDR_WIDTH:0]   eng_pend_base;
   logic [ADDR_WIDTH:0]   eng_pend_end;
   fra_pkg::act_type      act;

   assign accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fra_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (count_ff == '0) ? fra_pkg::ST_FLUSH : fra_pkg::ST_SCAN;
            end
         end
         fra_pkg::ST_SCAN: begin
            if (rem_ff == CW'(1)) begin
               state_in = fra_pkg::ST_FLUSH;
            end
         end
         fra_pkg::ST_FLUSH: begin
            state_in = fra_pkg::ST_DONE;
         end
         fra_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = fra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fra_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      do_scan   = 1'b0;
      do_flush  = 1'b0;
      do_post   = 1'b0;
      case (state_ff)
         fra_pkg::ST_IDLE:  req_stall = 1'b0;
         fra_pkg::ST_SCAN:  do_scan   = 1'b1;
         fra_pkg::ST_FLUSH: do_flush  = 1'b1;
         fra_pkg::ST_DONE:  do_post   = !rsp_valid_ff || !rsp_stall;
         default:           req_stall = 1'b1;
      endcase
   end

   // request decode: free and mark-used ranges are cut at the top address
   assign in_base   = ADDR_WIDTH'(req_base);
   assign in_size   = ADDR_WIDTH'(req_size);
   assign clip_size = (req_func != fra_pkg::FUNC_ALLOC && in_size > ~in_base)
                      ? ~in_base : in_size;

   assign active   = op_size_ff != '0;
   assign room     = live_ff < CW'(MAX_RANGES);
   assign pend_len = pend_end_ff - pend_base_ff;
   assign flush_place = func_ff == fra_pkg::FUNC_FREE && active && pend_ff;

   fra_engine #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_engine (
      .func         (func_ff),
      .active       (active),
      .op_base      (op_base_ff),
      .op_size      (op_size_ff),
      .op_end       (op_end_ff),
      .pend_base    (pend_base_ff),
      .pend_end     (pend_end_ff),
      .pend         (pend_ff),
      .found        (found_ff),
      .room         (room),
      .ent_base     (cell_base[0]),
      .ent_size     (cell_size[0]),
      .out_base0    (eng_base0),
      .out_size0    (eng_size0),
      .out_base1    (eng_base1),
      .out_size1    (eng_size1),
      .pend_base_nx (eng_pend_base),
      .pend_end_nx  (eng_pend_end),
      .act          (act)
   );

   // write-back slots: last live slot while scanning, next free one at flush
   assign live_dec = live_ff - CW'(1);
   assign wr_addr0 = do_flush ? live_ff[IW-1:0] : live_dec[IW-1:0];
   assign wr_addr1 = wr_addr0 + IW'(1);
   assign we0      = (do_scan && act.n_out != 2'd0) || (do_flush && flush_place && room);
   assign we1      = do_scan && act.n_out == 2'd2;
   assign wr_base0 = do_flush ? pend_base_ff[ADDR_WIDTH-1:0] : eng_base0;
   assign wr_size0 = do_flush ? pend_len[ADDR_WIDTH-1:0] : eng_size0;

   // chain of table cells, head at index 0
   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      logic [ADDR_WIDTH-1:0] nbr_base;
      logic [ADDR_WIDTH-1:0] nbr_size;
      if (i == MAX_RANGES - 1) begin : g_tail
         assign nbr_base = '0;
         assign nbr_size = '0;
      end else begin : g_body
         assign nbr_base = cell_base[i+1];
         assign nbr_size = cell_size[i+1];
      end
      fra_cell #(
         .ADDR_WIDTH  (ADDR_WIDTH),
         .INDEX_WIDTH (IW)
      ) u_cell (
         .clock    (clock),
         .my_index (IW'(i)),
         .shift    (do_scan),
         .we0      (we0),
         .we1      (we1),
         .wr_addr0 (wr_addr0),
         .wr_addr1 (wr_addr1),
         .wr_base0 (wr_base0),
         .wr_size0 (wr_size0),
         .wr_base1 (eng_base1),
         .wr_size1 (eng_size1),
         .nbr_base (nbr_base),
         .nbr_size (nbr_size),
         .base     (cell_base[i]),
         .size     (cell_size[i])
      );
   end

   // request and bookkeeping updates
   always_comb begin
      func_in       = func_ff;
      op_base_in    = op_base_ff;
      op_size_in    = op_size_ff;
      op_end_in     = op_end_ff;
      pend_base_in  = pend_base_ff;
      pend_end_in   = pend_end_ff;
      pend_in       = pend_ff;
      found_in      = found_ff;
      full_in       = full_ff;
      alloc_base_in = alloc_base_ff;
      count_in      = count_ff;
      live_in       = live_ff;
      rem_in        = rem_ff;
      if (accept) begin
         func_in      = fra_pkg::func_type'(req_func);
         op_base_in   = in_base;
         op_size_in   = clip_size;
         op_end_in    = {1'b0, in_base} + {1'b0, clip_size};
         pend_base_in = {1'b0, in_base};
         pend_end_in  = {1'b0, in_base} + {1'b0, clip_size};
         pend_in      = 1'b1;
         found_in     = 1'b0;
         full_in      = 1'b0;
         live_in      = count_ff;
         rem_in       = count_ff;
      end
      if (do_scan) begin
         rem_in       = rem_ff - CW'(1);
         live_in      = live_ff + CW'(act.n_out) - CW'(1);
         pend_base_in = eng_pend_base;
         pend_end_in  = eng_pend_end;
         if (act.place) begin
            pend_in = 1'b0;
         end
         if (act.drop) begin
            full_in = 1'b1;
         end
         if (act.hit) begin
            found_in      = 1'b1;
            alloc_base_in = cell_base[0];
         end
      end
      if (do_flush) begin
         count_in = live_ff;
         if (flush_place) begin
            if (room) begin
               count_in = live_ff + CW'(1);
            end else begin
               full_in = 1'b1;
            end
         end
      end
   end

   // result beat
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_base_in   = rsp_base_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_status_in = rsp_status_ff;
      if (do_post) begin
         rsp_valid_in  = 1'b1;
         rsp_base_in   = '0;
         rsp_size_in   = '0;
         rsp_status_in = full_ff ? fra_pkg::STATUS_FULL : fra_pkg::STATUS_OK;
         if (func_ff == fra_pkg::FUNC_ALLOC && active) begin
            if (found_ff) begin
               rsp_base_in = FW'(alloc_base_ff);
               rsp_size_in = FW'(op_size_ff);
            end else begin
               rsp_status_in = fra_pkg::STATUS_NO_FIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fra_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      op_base_ff    <= op_base_in;
      op_size_ff    <= op_size_in;
      op_end_ff     <= op_end_in;
      pend_base_ff  <= pend_base_in;
      pend_end_ff   <= pend_end_in;
      pend_ff       <= pend_in;
      found_ff      <= found_in;
      full_ff       <= full_in;
      alloc_base_ff <= alloc_base_in;
      live_ff       <= live_in;
      rem_ff        <= rem_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_base = rsp_base_ff;
   assign rsp_res_size = rsp_size_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

>>> hdl/fra_cell.sv
// ----------------------------------------------------------------------------
// fra_cell
// One table slot: holds a free range and shifts toward the head of the chain.
// ----------------------------------------------------------------------------
module fra_cell #(
   parameter int ADDR_WIDTH  = fra_pkg::ADDR_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH = 6
) (
   input  logic                   clock,
   input  logic [INDEX_WIDTH-1:0] my_index,
   input  logic                   shift,
   input  logic                   we0,
   input  logic                   we1,
   input  logic [INDEX_WIDTH-1:0] wr_addr0,
   input  logic [INDEX_WIDTH-1:0] wr_addr1,
   input  logic [ADDR_WIDTH-1:0]  wr_base0,
   input  logic [ADDR_WIDTH-1:0]  wr_size0,
   input  logic [ADDR_WIDTH-1:0]  wr_base1,
   input  logic [ADDR_WIDTH-1:0]  wr_size1,
   input  logic [ADDR_WIDTH-1:0]  nbr_base,
   input  logic [ADDR_WIDTH-1:0]  nbr_size,
   output logic [ADDR_WIDTH-1:0]  base,
   output logic [ADDR_WIDTH-1:0]  size
);

   logic [ADDR_WIDTH-1:0] base_ff, base_in;
   logic [ADDR_WIDTH-1:0] size_ff, size_in;

   // writes land in the post-shift frame, so they win over the shift
   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      if (we0 && wr_addr0 == my_index) begin
         base_in = wr_base0;
         size_in = wr_size0;
      end else if (we1 && wr_addr1 == my_index) begin
         base_in = wr_base1;
         size_in = wr_size1;
      end else if (shift) begin
         base_in = nbr_base;
         size_in = nbr_size;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      size_ff <= size_in;
   end

   assign base = base_ff;
   assign size = size_ff;

endmodule

>>> hdl/fra_engine.sv
// ----------------------------------------------------------------------------
// fra_engine
// Decides what becomes of the entry at the head of the chain for the
// request in progress: keep, trim, split, drop, or merge into a free range.
// ----------------------------------------------------------------------------
module fra_engine #(
   parameter int ADDR_WIDTH = fra_pkg::ADDR_WIDTH_DEFAULT
) (
   input  fra_pkg::func_type      func,
   input  logic                   active,   // request size nonzero
   input  logic [ADDR_WIDTH-1:0]  op_base,
   input  logic [ADDR_WIDTH-1:0]  op_size,
   input  logic [ADDR_WIDTH:0]    op_end,
   input  logic [ADDR_WIDTH:0]    pend_base,
   input  logic [ADDR_WIDTH:0]    pend_end,
   input  logic                   pend,
   input  logic                   found,
   input  logic                   room,     // table can take one more entry
   input  logic [ADDR_WIDTH-1:0]  ent_base,
   input  logic [ADDR_WIDTH-1:0]  ent_size,
   output logic [ADDR_WIDTH-1:0]  out_base0,
   output logic [ADDR_WIDTH-1:0]  out_size0,
   output logic [ADDR_WIDTH-1:0]  out_base1,
   output logic [ADDR_WIDTH-1:0]  out_size1,
   output logic [ADDR_WIDTH:0]    pend_base_nx,
   output logic [ADDR_WIDTH:0]    pend_end_nx,
   output fra_pkg::act_type       act
);

   logic [ADDR_WIDTH:0]   ent_b;
   logic [ADDR_WIDTH:0]   ent_e;
   logic [ADDR_WIDTH:0]   op_b;
   logic [ADDR_WIDTH:0]   pend_len;
   logic [ADDR_WIDTH-1:0] lower;
   logic [ADDR_WIDTH:0]   upper;

   assign ent_b    = {1'b0, ent_base};
   assign ent_e    = {1'b0, ent_base} + {1'b0, ent_size};
   assign op_b     = {1'b0, op_base};
   assign pend_len = pend_end - pend_base;
   assign lower    = (op_base > ent_base) ? op_base - ent_base : '0;
   assign upper    = (ent_e > op_end) ? ent_e - op_end : '0;

   always_comb begin
      act          = '0;
      act.n_out    = 2'd1;
      out_base0    = ent_base;
      out_size0    = ent_size;
      out_base1    = '0;
      out_size1    = '0;
      pend_base_nx = pend_base;
      pend_end_nx  = pend_end;
      case (func)
         fra_pkg::FUNC_ALLOC: begin
            // first fit: carve from the start of the entry
            if (active && !found && ent_size >= op_size) begin
               act.hit = 1'b1;
               if (ent_size == op_size) begin
                  act.n_out = 2'd0;
               end else begin
                  out_base0 = ent_base + op_size;
                  out_size0 = ent_size - op_size;
               end
            end
         end
         fra_pkg::FUNC_FREE: begin
            if (active && pend) begin
               if (ent_b <= pend_end && ent_e >= pend_base) begin
                  // touching or overlapping: fold into the pending range
                  act.absorb   = 1'b1;
                  act.n_out    = 2'd0;
                  pend_base_nx = (ent_b < pend_base) ? ent_b : pend_base;
                  pend_end_nx  = (ent_e > pend_end) ? ent_e : pend_end;
               end else if (ent_b > pend_end) begin
                  // first entry above: the pending range goes in front of it
                  act.place = 1'b1;
                  if (room) begin
                     act.n_out = 2'd2;
                     out_base0 = pend_base[ADDR_WIDTH-1:0];
                     out_size0 = pend_len[ADDR_WIDTH-1:0];
                     out_base1 = ent_base;
                     out_size1 = ent_size;
                  end else begin
                     act.drop = 1'b1;
                  end
               end
            end
         end
         fra_pkg::FUNC_MARK: begin
            if (active && !(ent_e <= op_b || ent_b >= op_end)) begin
               if (lower == '0 && upper == '0) begin
                  act.n_out = 2'd0;
               end else if (lower != '0 && upper != '0) begin
                  // range strictly inside: split, upper part needs a slot
                  out_size0 = lower;
                  if (room) begin
                     act.n_out = 2'd2;
                     out_base1 = op_end[ADDR_WIDTH-1:0];
                     out_size1 = upper[ADDR_WIDTH-1:0];
                  end else begin
                     act.drop = 1'b1;
                  end
               end else if (lower != '0) begin
                  out_size0 = lower;
               end else begin
                  out_base0 = op_end[ADDR_WIDTH-1:0];
                  out_size0 = upper[ADDR_WIDTH-1:0];
               end
            end
         end
         default: begin
            act.n_out = 2'd1;
         end
      endcase
   end

endmodule

>>> hdl/fra_checker.sv
// ----------------------------------------------------------------------------
// fra_checker
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fra_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_func,
   input logic [31:0] req_base,
   input logic [31:0] req_size,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_res_base,
   input logic [31:0] rsp_res_size,
   input logic [1:0]  rsp_status
);

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a stalled request beat stays up with the same payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_func)
      && $stable(req_base) && $stable(req_size))
      else $error("request beat changed while stalled");

   // one request at a time: busy right after a beat is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // a failed alloc reports an empty range
   a_no_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fra_pkg::STATUS_NO_FIT
      |-> rsp_res_size == '0 && rsp_res_base == '0)
      else $error("no-fit result carries a range");

   // a granted range always comes with an ok status
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_res_size != '0 |-> rsp_status == fra_pkg::STATUS_OK)
      else $error("granted range with error status");

endmodule

bind free_range_allocator_unit fra_checker u_fra_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_func     (req_func),
   .req_base     (req_base),
   .req_size     (req_size),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_res_base (rsp_res_base),
   .rsp_res_size (rsp_res_size),
   .rsp_status   (rsp_status)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for free_range_allocator_unit. A directed table covers
// the empty table, exact fit, merging, splitting, address-top clipping and
// the unused request kind. A table-fill pass then drives the table full. Random
// phases follow with mixed request kinds. Every result is checked field by
// field against a local model of the free table, with random idle cycles on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_ENTRIES  = fra_pkg::MAX_RANGES_DEFAULT;
   localparam int RANDOM_ITEMS = 1864;
   localparam int N_PHASES     = 8;
   localparam int IDLE_LIMIT   = 3000;
   localparam int LONG_HOLD    = 400;
   localparam longint unsigned ADDR_TOP = 64'hFFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = fra_pkg::FUNC_ALLOC;
   logic [31:0] req_base = '0;
   logic [31:0] req_size = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_res_base;
   logic [31:0] rsp_res_size;
   logic [1:0]  rsp_status;

   typedef struct {
      logic [31:0] base;
      logic [31:0] size;
      logic [1:0]  status;
   } outcome_type;

   typedef struct {
      logic [1:0]  func;
      logic [31:0] base;
      logic [31:0] size;
      bit          typed;
      outcome_type want;
   } stim_row_type;

   // local copy of the free table, sorted by base
   longint unsigned free_base_q[$];
   longint unsigned free_size_q[$];
   outcome_type     pending_q[$];

   int  errors = 0;
   int  n_sent = 0;
   int  n_checked = 0;
   int  n_full = 0;
   int  n_nofit = 0;
   int  deepest = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   bit  hold_long = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   free_range_allocator_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_base     (req_base),
      .req_size     (req_size),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_res_base (rsp_res_base),
      .rsp_res_size (rsp_res_size),
      .rsp_status   (rsp_status)
   );

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
   endtask

   // apply one request to the free table and return what the block must answer
   function automatic outcome_type apply_request(input logic [1:0] func,
                                                 input logic [31:0] base,
                                                 input logic [31:0] size);
      outcome_type     r;
      longint unsigned b, s, e, nb, ne, eb, ee, lo, hi;
      int              i, pos;
      r = '{base: '0, size: '0, status: fra_pkg::STATUS_OK};
      b = 64'(base);
      s = 64'(size);
      if (func == fra_pkg::FUNC_ALLOC) begin
         if (s != 0) begin
            r.status = fra_pkg::STATUS_NO_FIT;
            for (i = 0; i < free_size_q.size(); i++) begin
               if (free_size_q[i] >= s) begin
                  r.base   = 32'(free_base_q[i]);
                  r.size   = size;
                  r.status = fra_pkg::STATUS_OK;
                  if (free_size_q[i] == s) begin
                     free_base_q.delete(i);
                     free_size_q.delete(i);
                  end else begin
                     free_base_q[i] += s;
                     free_size_q[i] -= s;
                  end
                  break;
               end
            end
         end
      end else if (func == fra_pkg::FUNC_FREE || func == fra_pkg::FUNC_MARK) begin
         // clip the range at the top of the address space
         if (s > ADDR_TOP - b) s = ADDR_TOP - b;
         e = b + s;
         if (s != 0 && func == fra_pkg::FUNC_FREE) begin
            nb = b;
            ne = e;
            i  = 0;
            while (i < free_base_q.size()) begin
               eb = free_base_q[i];
               ee = eb + free_size_q[i];
               if (eb <= ne && ee >= nb) begin
                  if (eb < nb) nb = eb;
                  if (ee > ne) ne = ee;
                  free_base_q.delete(i);
                  free_size_q.delete(i);
               end else begin
                  i++;
               end
            end
            pos = 0;
            while (pos < free_base_q.size() && free_base_q[pos] < nb) pos++;
            if (free_base_q.size() >= MAX_ENTRIES) begin
               r.status = fra_pkg::STATUS_FULL;
            end else begin
               free_base_q.insert(pos, nb);
               free_size_q.insert(pos, ne - nb);
            end
         end else if (s != 0) begin
            i = 0;
            while (i < free_base_q.size()) begin
               eb = free_base_q[i];
               ee = eb + free_size_q[i];
               if (ee <= b || eb >= e) begin
                  i++;
               end else begin
                  lo = (b > eb) ? b - eb : 0;
                  hi = (ee > e) ? ee - e : 0;
                  if (lo == 0 && hi == 0) begin
                     free_base_q.delete(i);
                     free_size_q.delete(i);
                  end else if (lo != 0 && hi != 0) begin
                     free_size_q[i] = lo;
                     if (free_base_q.size() >= MAX_ENTRIES) begin
                        // upper part is lost
                        r.status = fra_pkg::STATUS_FULL;
                        i++;
                     end else begin
                        free_base_q.insert(i + 1, e);
                        free_size_q.insert(i + 1, hi);
                        i += 2;
                     end
                  end else if (lo != 0) begin
                     free_size_q[i] = lo;
                     i++;
                  end else begin
                     free_base_q[i] = e;
                     free_size_q[i] = hi;
                     i++;
                  end
               end
            end
         end
      end
      if (free_base_q.size() > deepest) deepest = free_base_q.size();
      return r;
   endfunction

   // offer one beat, wait for it to be taken, then record the expectation
   task automatic send_beat(input logic [1:0] func, input logic [31:0] base,
                            input logic [31:0] size, input bit typed,
                            input outcome_type want);
      outcome_type pred;
      int          gap;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_base  <= base;
      req_size  <= size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = apply_request(func, base, size);
      pending_q.push_back(typed ? want : pred);
      if (pred.status == fra_pkg::STATUS_FULL) n_full++;
      if (pred.status == fra_pkg::STATUS_NO_FIT) n_nofit++;
      n_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending_q.size() == 0);
      @(posedge clock);
   endtask

   // random request; fill-heavy phases favor small disjoint frees
   task automatic random_beat(input int phase);
      logic [1:0]  func;
      logic [31:0] base, size;
      int          pick;
      bit          fill;
      fill = (phase % 3 == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         func = 2'($urandom_range(0, 3));
         base = $urandom();
         size = $urandom();
      end else begin
         pick = $urandom_range(0, 99);
         if (fill) func = (pick < 70) ? fra_pkg::FUNC_FREE :
                          (pick < 85) ? fra_pkg::FUNC_ALLOC : fra_pkg::FUNC_MARK;
         else      func = (pick < 35) ? fra_pkg::FUNC_FREE :
                          (pick < 70) ? fra_pkg::FUNC_ALLOC : fra_pkg::FUNC_MARK;
         base = 32'h0001_0000 + $urandom_range(0, 1023) * 32'h40 + $urandom_range(0, 3);
         if ($urandom_range(0, 9) == 0) size = $urandom_range(1, 16'hFFFF);
         else                           size = $urandom_range(1, fill ? 24 : 160);
         if ($urandom_range(0, 49) == 0) size = 0;
      end
      send_beat(func, base, size, 1'b0, '{base: '0, size: '0, status: fra_pkg::STATUS_OK});
   endtask

   // receiver: random stall before each beat, one long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end
         n = quiet ? 0 : $urandom_range(0, 8);
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            $display("[%0t] result beat with nothing expected", $time);
            errors++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_res_base !== want.base) report("res_base", rsp_res_base, want.base);
            if (rsp_res_size !== want.size) report("res_size", rsp_res_size, want.size);
            if (rsp_status !== want.status)
               report("status", 32'(rsp_status), 32'(want.status));
            n_checked++;
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      int           k, p;
      rows = '{
         // alloc on an empty table
         '{fra_pkg::FUNC_ALLOC, 32'h0, 32'h10, 1'b1, '{32'h0, 32'h0, fra_pkg::STATUS_NO_FIT}},
         '{fra_pkg::FUNC_FREE, 32'h1000, 32'h100, 1'b1, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         // zero sizes change nothing
         '{fra_pkg::FUNC_ALLOC, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_FREE, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         // free below every entry, then exact fit
         '{fra_pkg::FUNC_FREE, 32'h100, 32'h100, 1'b1, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_ALLOC, 32'h0, 32'h100, 1'b1,
           '{32'h100, 32'h100, fra_pkg::STATUS_OK}},
         // touching and overlapping frees merge
         '{fra_pkg::FUNC_FREE, 32'h1100, 32'h100, 1'b0, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_FREE, 32'h1080, 32'h200, 1'b0, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_ALLOC, 32'h0, 32'h20, 1'b0, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         // split, then remove everything inside a used range
         '{fra_pkg::FUNC_MARK, 32'h1100, 32'h10, 1'b0, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_MARK, 32'h1000, 32'h2000, 1'b0, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         // range clipped at the top of the address space
         '{fra_pkg::FUNC_FREE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1,
           '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_ALLOC, 32'h0, 32'hFFFF_FFFF, 1'b1,
           '{32'h0, 32'h0, fra_pkg::STATUS_NO_FIT}},
         '{2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 32'hF, 1'b1,
           '{32'hFFFF_FFF0, 32'hF, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_FREE, 32'h0, 32'hFFFF_FFFF, 1'b1,
           '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_ALLOC, 32'h0, 32'hFFFF_FFFF, 1'b1,
           '{32'h0, 32'hFFFF_FFFF, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_MARK, 32'h10, 32'h10, 1'b1, '{32'h0, 32'h0, fra_pkg::STATUS_OK}},
         '{fra_pkg::FUNC_ALLOC, 32'h0, 32'h1, 1'b1, '{32'h0, 32'h0, fra_pkg::STATUS_NO_FIT}}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_beat(rows[i].func, rows[i].base, rows[i].size, rows[i].typed,
                                  rows[i].want);

      // fill the table, then overflow it by free and by split
      for (k = 0; k < MAX_ENTRIES; k++)
         send_beat(fra_pkg::FUNC_FREE, k * 32'h100, 32'h10, 1'b0,
                   '{32'h0, 32'h0, fra_pkg::STATUS_OK});
      send_beat(fra_pkg::FUNC_FREE, 32'h8000, 32'h10, 1'b1,
                '{32'h0, 32'h0, fra_pkg::STATUS_FULL});
      send_beat(fra_pkg::FUNC_MARK, 32'h204, 32'h4, 1'b1,
                '{32'h0, 32'h0, fra_pkg::STATUS_FULL});
      send_beat(fra_pkg::FUNC_MARK, 32'h0, 32'hFFFF_FFFF, 1'b1,
                '{32'h0, 32'h0, fra_pkg::STATUS_OK});
      drain();

      for (p = 0; p < N_PHASES; p++) begin
         quiet = (p == 2 || p == 5);
         for (k = 0; k < RANDOM_ITEMS / N_PHASES; k++) begin
            if (p == 3 && k == 20) hold_long = 1'b1;
            random_beat(p);
         end
         // sender pauses until everything is back
         drain();
      end

      quiet = 1'b0;
      repeat (100) @(posedge clock);
      $display("%0d requests sent, %0d results checked", n_sent, n_checked);
      $display("%0d no-fit, %0d table-full drops, deepest table %0d entries",
               n_nofit, n_full, deepest);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
